/* hdl/fir_filter_programmable_taps_unit_defines.svh */
// Assertion helpers shared by the filter RTL.
// The enclosing module must have i_clk and i_rst_n in scope.
`ifndef FIR_FILTER_PROGRAMMABLE_TAPS_UNIT_DEFINES_SVH
`define FIR_FILTER_PROGRAMMABLE_TAPS_UNIT_DEFINES_SVH

// Check a property outside of reset.
`define FPT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property at every rising clock edge, reset included.
`define FPT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* hdl/fir_pt_pkg.sv */
package fir_pt_pkg;

    // Window size and field widths
    localparam int MAX_TAPS  = 7;
    localparam int SAMPLE_W  = 16;
    localparam int GAIN_W    = 16;
    localparam int PROD_W    = SAMPLE_W + GAIN_W;
    localparam int SUM_W     = 34;
    localparam int TAP_CNT_W = $clog2(MAX_TAPS + 1);
    localparam int REG_IDX_W = 3;
    localparam int PADDR_W   = REG_IDX_W + 2;
    localparam int PDATA_W   = 32;

    typedef logic signed [SAMPLE_W-1:0]  t_sample;
    typedef logic signed [GAIN_W-1:0]    t_gain;
    typedef logic signed [PROD_W-1:0]    t_prod;
    typedef logic signed [SUM_W-1:0]     t_sum;
    typedef logic        [TAP_CNT_W-1:0] t_tap_cnt;
    typedef logic        [REG_IDX_W-1:0] t_reg_idx;

    // Register map indexes
    localparam t_reg_idx REG_TAP_COUNT = 3'd0;
    localparam t_reg_idx REG_GAIN_BASE = 3'd1;

    // Reset values
    localparam t_tap_cnt TAP_COUNT_RESET = 3'd6;
    localparam t_gain GAIN_RESET [MAX_TAPS] = '{
        16'sd865, 16'sd4604, 16'sd10915, 16'sd10915, 16'sd4604, 16'sd865, 16'sd0
    };

    // Controls broadcast from the top level to every cell
    typedef struct packed {
        logic shift;  // advance the delay line
        logic mul;    // capture the product of tap and gain
        logic en;     // advance the partial sum chain
    } t_cell_ctl;

endpackage

/* hdl/fir_pt_sample_if.sv */
interface fir_pt_sample_if
    import fir_pt_pkg::*;
();
    logic    valid;
    logic    ready;
    t_sample sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

/* hdl/fir_pt_result_if.sv */
interface fir_pt_result_if
    import fir_pt_pkg::*;
();
    logic valid;
    logic ready;
    t_sum filtered;

    modport source (output valid, output filtered, input ready);
    modport sink   (input valid, input filtered, output ready);
endinterface

/* hdl/fir_pt_cell.sv */
module fir_pt_cell
    import fir_pt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_sample   i_sample,
    input  t_gain     i_gain,
    input  t_sum      i_psum,
    input  logic      i_tok,
    output t_sample   o_sample,
    output t_sum      o_psum,
    output logic      o_tok
);

    t_sample r_sample;
    t_prod   r_prod;
    t_prod   n_prod;
    t_sum    r_psum;
    t_sum    n_psum;
    logic    r_tok;

    // Delay line tap, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample <= '0;
        end else if (i_ctl.shift) begin
            r_sample <= i_sample;
        end
    end

    // Weight the tap
    assign n_prod = t_prod'(r_sample) * t_prod'(i_gain);

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul) begin
            r_prod <= n_prod;
        end
    end

    // Add own product to the sum handed over by the neighbor
    assign n_psum = i_psum + t_sum'(r_prod);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_psum <= n_psum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= 1'b0;
        end else if (i_ctl.en) begin
            r_tok <= i_tok;
        end
    end

    assign o_sample = r_sample;
    assign o_psum   = r_psum;
    assign o_tok    = r_tok;

endmodule

/* hdl/fir_filter_programmable_taps_unit.sv */
// Channel     | Direction | Payload            | Transaction
// ------------+-----------+--------------------+---------------------------
// i_sample_if | in        | sample, s16        | valid & ready at i_clk rise
// o_result_if | out       | filtered, s34      | valid & ready at i_clk rise
// APB         | in        | tap_count, gain_0-6| psel & penable & pwrite
//
// A result follows its input transaction through the product register; the partial sum
// then walks the seven cells one per cycle, then lands in the output register.
// The next sample is taken once the previous sum has reached the output
// register, so a new sample waits until the previous sum is through.
// A stalled output holds the finished sum in the last cell and blocks input.
// Synchronous active-low reset zeroes the delay line and restores the gains and tap count.
`include "fir_filter_programmable_taps_unit_defines.svh"

module fir_filter_programmable_taps_unit
    import fir_pt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    fir_pt_sample_if.sink        i_sample_if,
    fir_pt_result_if.source      o_result_if,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

    t_tap_cnt  r_tap_count;
    t_gain     r_gain [MAX_TAPS];
    t_reg_idx  w_reg_idx;
    t_reg_idx  w_gain_idx;
    logic      w_cfg_wr;

    logic      r_busy;
    logic      r_go;
    logic      r_start;
    logic      r_out_valid;
    t_sum      r_out;
    logic      w_accept;
    logic      w_transfer;
    logic      w_en;
    t_cell_ctl w_ctl;

    t_sample   w_smp_in  [MAX_TAPS];
    t_sample   w_smp_out [MAX_TAPS];
    t_gain     w_gain    [MAX_TAPS];
    t_sum      w_psum_in [MAX_TAPS];
    t_sum      w_psum_out[MAX_TAPS];
    logic [MAX_TAPS-1:0] w_tok_in;
    logic [MAX_TAPS-1:0] w_tok;

    // Register file access
    assign pready     = 1'b1;
    assign w_reg_idx  = paddr[PADDR_W-1:2];
    assign w_gain_idx = w_reg_idx - REG_GAIN_BASE;
    assign w_cfg_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= TAP_COUNT_RESET;
            for (int i = 0; i < MAX_TAPS; i++) begin
                r_gain[i] <= GAIN_RESET[i];
            end
        end else if (w_cfg_wr) begin
            if (w_reg_idx == REG_TAP_COUNT) begin
                r_tap_count <= pwdata[TAP_CNT_W-1:0];
            end else begin
                r_gain[w_gain_idx] <= pwdata[GAIN_W-1:0];
            end
        end
    end

    always_comb begin
        if (w_reg_idx == REG_TAP_COUNT) begin
            prdata = {{(PDATA_W-TAP_CNT_W){1'b0}}, r_tap_count};
        end else begin
            prdata = {{(PDATA_W-GAIN_W){1'b0}}, r_gain[w_gain_idx]};
        end
    end

    // Route gain n-1-a to the cell holding the sample of age a
    always_comb begin
        for (int a = 0; a < MAX_TAPS; a++) begin
            if (TAP_CNT_W'(a) < r_tap_count) begin
                w_gain[a] = r_gain[REG_IDX_W'(r_tap_count - TAP_CNT_W'(a) - TAP_CNT_W'(1))];
            end else begin
                w_gain[a] = '0;
            end
        end
    end

    // Handshake and sequencing
    assign i_sample_if.ready = !r_busy;
    assign w_accept   = i_sample_if.valid && !r_busy;
    assign w_transfer = w_tok[MAX_TAPS-1] && (!r_out_valid || o_result_if.ready);
    assign w_en       = !w_tok[MAX_TAPS-1] || w_transfer;

    assign w_ctl.shift = w_accept;
    assign w_ctl.mul   = r_go;
    assign w_ctl.en    = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_go    <= 1'b0;
            r_start <= 1'b0;
        end else begin
            r_go    <= w_accept;
            r_start <= r_go;
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_transfer) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_transfer) begin
            r_out_valid <= 1'b1;
        end else if (o_result_if.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_transfer) begin
            r_out <= w_psum_out[MAX_TAPS-1];
        end
    end

    assign o_result_if.valid    = r_out_valid;
    assign o_result_if.filtered = r_out;

    // Row of cells: delay line forward, partial sum forward
    for (genvar g = 0; g < MAX_TAPS; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign w_smp_in[g]  = i_sample_if.sample;
            assign w_psum_in[g] = '0;
            assign w_tok_in[g]  = r_start;
        end else begin : g_body
            assign w_smp_in[g]  = w_smp_out[g-1];
            assign w_psum_in[g] = w_psum_out[g-1];
            assign w_tok_in[g]  = w_tok[g-1];
        end

        fir_pt_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_ctl),
            .i_sample (w_smp_in[g]),
            .i_gain   (w_gain[g]),
            .i_psum   (w_psum_in[g]),
            .i_tok    (w_tok_in[g]),
            .o_sample (w_smp_out[g]),
            .o_psum   (w_psum_out[g]),
            .o_tok    (w_tok[g])
        );
    end

    `FPT_ASSERT_ALWAYS(a_pready_high, pready, "pready dropped")
    `FPT_ASSERT(a_single_item, $onehot0({r_go, r_start, w_tok}), "cell row holds two sums")
    `FPT_ASSERT(a_idle_row_empty, !r_busy |-> !(r_go || r_start || (|w_tok)), "row busy while idle")
    `FPT_ASSERT(a_transfer_loads, w_transfer |=> r_out_valid, "finished sum not loaded to output")
    `FPT_ASSERT(a_last_held, (w_tok[MAX_TAPS-1] && !w_en) |=> w_tok[MAX_TAPS-1], "stalled sum dropped")

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps

module testbench;
    import fir_pt_pkg::*;

    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 12;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    fir_pt_sample_if smp_if();
    fir_pt_result_if res_if();

    fir_filter_programmable_taps_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample_if (smp_if),
        .o_result_if (res_if),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // Free-running clock, 20 ns period
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Filter model: window history, gains and tap count as the block holds them
    t_sample  sample_history [MAX_TAPS];
    t_gain    gain_model     [MAX_TAPS];
    t_tap_cnt taps_model;
    t_sum     expected_filtered [$];

    int failures      = 0;
    int hold_requests = 0;
    bit idle_on       = 1'b1;

    // Weighted sum of the window ending at cur, then push cur into the history
    function automatic t_sum next_filtered(t_sample cur);
        longint  acc;
        int      n;
        int      age;
        t_sample tap;
        acc = 0;
        n   = taps_model;
        for (int k = 0; k < n; k++) begin
            age = n - 1 - k;
            tap = (age == 0) ? cur : sample_history[age-1];
            acc += longint'(gain_model[k]) * longint'(tap);
        end
        for (int k = MAX_TAPS - 1; k > 0; k--) begin
            sample_history[k] = sample_history[k-1];
        end
        sample_history[0] = cur;
        return t_sum'(acc);
    endfunction

    // Full-scale values often, small values sometimes, otherwise anything
    function automatic logic signed [15:0] rand_q15();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sh0000;
            3: return 16'($signed($urandom_range(0, 15)) - 8);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic note_failure(string what);
        failures++;
        if (failures <= 10) begin
            $display("mismatch %0d: %s", failures, what);
        end
    endtask

    // APB write: setup cycle, then access cycle until pready
    task automatic write_register(t_reg_idx idx, logic [PDATA_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_TAP_COUNT) begin
            taps_model = value[TAP_CNT_W-1:0];
        end else begin
            gain_model[idx - REG_GAIN_BASE] = value[GAIN_W-1:0];
        end
    endtask

    task automatic write_gain(int k, t_gain g);
        write_register(t_reg_idx'(REG_GAIN_BASE + k), {{(PDATA_W-GAIN_W){g[GAIN_W-1]}}, g});
    endtask

    // Offer one sample, optionally after an idle burst; record its sum on accept
    task automatic send_sample(t_sample s);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            smp_if.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        smp_if.valid  <= 1'b1;
        smp_if.sample <= s;
        do @(posedge i_clk); while (!smp_if.ready);
        expected_filtered.push_back(next_filtered(s));
    endtask

    // Drop valid, wait for every pending sum, then wait out the DRAIN_CYCLES margin
    task automatic wait_drained();
        smp_if.valid <= 1'b0;
        while (expected_filtered.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Random tap count and gains, every register written
    task automatic write_random_settings();
        write_register(REG_TAP_COUNT, PDATA_W'($urandom_range(0, 7)));
        for (int k = 0; k < MAX_TAPS; k++) begin
            write_gain(k, rand_q15());
        end
    endtask

    // Impulse through the reset gains, start-up history reads as zero
    task automatic test_reset_defaults();
        send_sample(16'sh7fff);
        repeat (6) send_sample(16'sh0000);
        wait_drained();
    endtask

    // Largest positive and largest negative sums with seven full-scale taps
    task automatic test_extremes();
        write_register(REG_TAP_COUNT, PDATA_W'(MAX_TAPS));
        for (int k = 0; k < MAX_TAPS; k++) begin
            write_gain(k, 16'sh8000);
        end
        repeat (7) send_sample(16'sh8000);
        repeat (7) send_sample(16'sh7fff);
        wait_drained();
    endtask

    // Zero taps gives an empty sum; one tap ignores the upper gains
    task automatic test_tap_boundaries();
        write_register(REG_TAP_COUNT, PDATA_W'(0));
        send_sample(16'sh1234);
        send_sample(16'sh8000);
        wait_drained();
        write_register(REG_TAP_COUNT, PDATA_W'(1));
        write_gain(0, 16'sh4000);
        write_gain(MAX_TAPS - 1, 16'sh7fff);
        send_sample(16'sh7fff);
        send_sample(16'shc000);
        wait_drained();
    endtask

    // Several random settings, random samples, idling on both sides
    task automatic test_random_settings();
        for (int phase = 0; phase < 8; phase++) begin
            write_random_settings();
            repeat (200) send_sample(rand_q15());
            wait_drained();
        end
    endtask

    // Receiver holds off for a long stretch while samples keep coming
    task automatic test_backpressure();
        write_random_settings();
        hold_requests <= hold_requests + 1;
        repeat (40) send_sample(rand_q15());
        wait_drained();
    endtask

    // Back-to-back stream with no idling on either side
    task automatic test_steady_stream();
        idle_on <= 1'b0;
        write_random_settings();
        repeat (300) send_sample(rand_q15());
        wait_drained();
    endtask

    // Result sink: check each transaction, drive ready with stalls and hold-off
    initial begin : result_sink
        int   stall_left;
        int   hold_left;
        int   seen_requests;
        t_sum want;
        stall_left    = 0;
        hold_left     = 0;
        seen_requests = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_if.valid && res_if.ready) begin
                if (expected_filtered.size() == 0) begin
                    note_failure($sformatf("unexpected result %0d", res_if.filtered));
                end else begin
                    want = expected_filtered.pop_front();
                    if (res_if.filtered !== want) begin
                        note_failure($sformatf("filtered expected %0d, got %0d",
                                               want, res_if.filtered));
                    end
                end
            end
            if (seen_requests != hold_requests) begin
                seen_requests = hold_requests;
                hold_left     = $urandom_range(300, 500);
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                res_if.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                stall_left   = $urandom_range(1, 19) - 1;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run after too many cycles without any transaction
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((smp_if.valid && smp_if.ready) || (res_if.valid && res_if.ready) ||
                (psel && penable && pwrite && pready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("FAIL fir_filter_programmable_taps_unit");
        $finish;
    end

    // Main sequence
    initial begin
        i_rst_n       <= 1'b0;
        smp_if.valid  <= 1'b0;
        smp_if.sample <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        taps_model = TAP_COUNT_RESET;
        gain_model = GAIN_RESET;
        for (int k = 0; k < MAX_TAPS; k++) begin
            sample_history[k] = '0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_extremes();
        test_tap_boundaries();
        test_random_settings();
        test_backpressure();
        test_steady_stream();

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (failures == 0 && expected_filtered.size() == 0) begin
            $display("PASS fir_filter_programmable_taps_unit");
        end else begin
            $display("FAIL fir_filter_programmable_taps_unit");
        end
        $finish;
    end

endmodule
